// File: sv/tvs_pkg.sv
// shared constants, codes and state types of the trilinear voxel sampler
package tvs_pkg;

  localparam int unsigned DEF_MAX_DIM_X = 64;
  localparam int unsigned DEF_MAX_DIM_Y = 64;
  localparam int unsigned DEF_MAX_DIM_Z = 64;
  localparam int unsigned DEF_FRAC_BITS = 8;

  localparam int unsigned POS_W         = 14;
  localparam int unsigned VOXEL_INDEX_W = 18;
  localparam int unsigned VOXEL_W       = 8;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned OUT_FRAC      = 8;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned READS       = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_e;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: sv/trilinear_voxel_sampler_core.sv
// top level of the trilinear voxel sampler
// a sample passes front end states F_MUL1, F_MUL2 and F_PUSH, the two-entry queue, the eight
// reads of the single-ported volume memory and the x, y, z blend registers up to its done
// strobe; no entry is popped before a sample's last read; the queue lets the front run ahead
// results leave on a one-cycle done strobe, since the receiver cannot stall
// reset sets the dimension registers to 64 and empties the queue; volume memory stays undefined
module trilinear_voxel_sampler_core #(
  parameter int unsigned MAX_DIM_X = tvs_pkg::DEF_MAX_DIM_X,
  parameter int unsigned MAX_DIM_Y = tvs_pkg::DEF_MAX_DIM_Y,
  parameter int unsigned MAX_DIM_Z = tvs_pkg::DEF_MAX_DIM_Z,
  parameter int unsigned FRAC_BITS = tvs_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func_i,
  input  logic [tvs_pkg::VOXEL_INDEX_W-1:0]  voxel_index_i,
  input  logic [tvs_pkg::VOXEL_W-1:0]        voxel_value_i,
  input  logic [tvs_pkg::POS_W-1:0]          pos_x_i,
  input  logic [tvs_pkg::POS_W-1:0]          pos_y_i,
  input  logic [tvs_pkg::POS_W-1:0]          pos_z_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tvs_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [tvs_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic [tvs_pkg::SAMPLE_W-1:0]       sample_value_o
);
  import tvs_pkg::*;

  localparam int unsigned DW = $clog2(max_u(max_u(MAX_DIM_X, MAX_DIM_Y), MAX_DIM_Z));
  localparam int unsigned STORE_SIZE = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);

  typedef struct packed {
    logic                   is_load;
    logic [ADDR_W-1:0]      load_addr;
    logic [VOXEL_W-1:0]     load_value;
    logic [3:0][ADDR_W-1:0] base;
    logic [DW-1:0]          x0;
    logic [DW-1:0]          x1;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fy;
    logic [FRAC_BITS-1:0]   fz;
  } entry_t;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop;
  entry_t pop_entry;

  tvs_front #(
    .MAX_DIM_X (MAX_DIM_X),
    .MAX_DIM_Y (MAX_DIM_Y),
    .MAX_DIM_Z (MAX_DIM_Z),
    .FRAC_BITS (FRAC_BITS),
    .entry_t   (entry_t)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .voxel_index_i (voxel_index_i),
    .voxel_value_i (voxel_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  tvs_queue #(
    .entry_t (entry_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_entry)
  );

  tvs_back #(
    .MAX_DIM_X (MAX_DIM_X),
    .MAX_DIM_Y (MAX_DIM_Y),
    .MAX_DIM_Z (MAX_DIM_Z),
    .FRAC_BITS (FRAC_BITS),
    .entry_t   (entry_t)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_o          (pop),
    .pop_data_i     (pop_entry),
    .done_o         (done_o),
    .sample_value_o (sample_value_o)
  );

endmodule

// File: sv/tvs_front.sv
// front end: command intake, config registers, coordinate split and row address set-up
module tvs_front #(
  parameter int unsigned MAX_DIM_X = tvs_pkg::DEF_MAX_DIM_X,
  parameter int unsigned MAX_DIM_Y = tvs_pkg::DEF_MAX_DIM_Y,
  parameter int unsigned MAX_DIM_Z = tvs_pkg::DEF_MAX_DIM_Z,
  parameter int unsigned FRAC_BITS = tvs_pkg::DEF_FRAC_BITS,
  parameter type entry_t = logic
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic [tvs_pkg::VOXEL_INDEX_W-1:0]   voxel_index_i,
  input  logic [tvs_pkg::VOXEL_W-1:0]         voxel_value_i,
  input  logic [tvs_pkg::POS_W-1:0]           pos_x_i,
  input  logic [tvs_pkg::POS_W-1:0]           pos_y_i,
  input  logic [tvs_pkg::POS_W-1:0]           pos_z_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tvs_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [tvs_pkg::CFG_W-1:0]           cfg_data_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output entry_t                              push_entry_o
);
  import tvs_pkg::*;

  localparam int unsigned DW = $clog2(max_u(max_u(MAX_DIM_X, MAX_DIM_Y), MAX_DIM_Z));
  localparam int unsigned STORE_SIZE = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);
  localparam int unsigned CW = max_u(POS_W, DW + FRAC_BITS);
  localparam int unsigned EW = max_u(CFG_W, DW + 1);
  localparam int unsigned LW = max_u(ADDR_W + 1, VOXEL_INDEX_W);
  localparam int unsigned MAXD [3] = '{MAX_DIM_X, MAX_DIM_Y, MAX_DIM_Z};

  front_state_e state_q, state_d;

  logic [CFG_W-1:0] dim_q [3];
  logic [CFG_W-1:0] dim_d [3];
  logic [DW-1:0]    dimm1 [3];

  logic [POS_W-1:0]     pos   [3];
  logic [DW-1:0]        lo_d  [3];
  logic [DW-1:0]        hi_d  [3];
  logic [FRAC_BITS-1:0] frac_d [3];
  logic [DW-1:0]        lo_q  [3];
  logic [DW-1:0]        hi_q  [3];
  logic [FRAC_BITS-1:0] frac_q [3];

  logic [LW-1:0]      idx_ext;
  logic               idx_ok;
  logic               accept;
  logic               func_q;
  logic [ADDR_W-1:0]  load_addr_q;
  logic [VOXEL_W-1:0] load_value_q;

  logic [ADDR_W-1:0] w_ext, h_ext;
  logic [ADDR_W-1:0] wh_q, y0w_q, y1w_q, z0wh_q, z1wh_q;

  entry_t entry;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dim_d[a] = dim_q[a];
    end
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  dim_d[0] = cfg_data_i;
        CFG_HEIGHT: dim_d[1] = cfg_data_i;
        CFG_DEPTH:  dim_d[2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        dim_q[a] <= CFG_DIM_RESET;
      end
    end else begin
      for (int a = 0; a < 3; a++) begin
        dim_q[a] <= dim_d[a];
      end
    end
  end

  // effective dimension minus one, zero taken as one, saturated to the maximum
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dim_q[a] == '0) begin
        dimm1[a] = '0;
      end else if (EW'(dim_q[a]) > EW'(MAXD[a])) begin
        dimm1[a] = DW'(MAXD[a] - 1);
      end else begin
        dimm1[a] = DW'(dim_q[a] - CFG_W'(1));
      end
    end
  end

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_comb begin
    logic [CW-1:0] top_v;
    logic [CW-1:0] sat;
    for (int a = 0; a < 3; a++) begin
      top_v = CW'(dimm1[a]) << FRAC_BITS;
      sat   = (CW'(pos[a]) > top_v) ? top_v : CW'(pos[a]);
      lo_d[a]   = DW'(sat >> FRAC_BITS);
      frac_d[a] = sat[FRAC_BITS-1:0];
      hi_d[a]   = (lo_d[a] == dimm1[a]) ? lo_d[a] : lo_d[a] + DW'(1);
    end
  end

  assign idx_ext = LW'(voxel_index_i);
  assign idx_ok  = idx_ext < LW'(STORE_SIZE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (func_e'(func_i) == FUNC_SAMPLE) begin
            state_d = F_MUL1;
          end else if (idx_ok) begin
            state_d = F_PUSH;
          end
        end
      end
      F_MUL1: state_d = F_MUL2;
      F_MUL2: state_d = F_PUSH;
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign w_ext = ADDR_W'(dimm1[0]) + ADDR_W'(1);
  assign h_ext = ADDR_W'(dimm1[1]) + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= func_i;
      load_addr_q  <= idx_ext[ADDR_W-1:0];
      load_value_q <= voxel_value_i;
      for (int a = 0; a < 3; a++) begin
        lo_q[a]   <= lo_d[a];
        hi_q[a]   <= hi_d[a];
        frac_q[a] <= frac_d[a];
      end
    end
    if (state_q == F_MUL1) begin
      wh_q  <= w_ext * h_ext;
      y0w_q <= ADDR_W'(lo_q[1]) * w_ext;
      y1w_q <= ADDR_W'(hi_q[1]) * w_ext;
    end
    if (state_q == F_MUL2) begin
      z0wh_q <= ADDR_W'(lo_q[2]) * wh_q;
      z1wh_q <= ADDR_W'(hi_q[2]) * wh_q;
    end
  end

  always_comb begin
    busy         = (state_q != F_IDLE);
    push_valid_o = (state_q == F_PUSH);
    entry.is_load    = (func_e'(func_q) == FUNC_LOAD);
    entry.load_addr  = load_addr_q;
    entry.load_value = load_value_q;
    entry.base[0]    = z0wh_q + y0w_q;
    entry.base[1]    = z0wh_q + y1w_q;
    entry.base[2]    = z1wh_q + y0w_q;
    entry.base[3]    = z1wh_q + y1w_q;
    entry.x0         = lo_q[0];
    entry.x1         = hi_q[0];
    entry.fx         = frac_q[0];
    entry.fy         = frac_q[1];
    entry.fz         = frac_q[2];
    push_entry_o     = entry;
  end

endmodule

// File: sv/tvs_queue.sv
// short command queue between the front and back ends
module tvs_queue #(
  parameter type entry_t = logic,
  parameter int unsigned DEPTH = tvs_pkg::QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_i,
  output entry_t pop_data_o
);
  import tvs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  entry_t        slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/tvs_back.sv
// back end: voxel memory, eight neighbour reads and the x, y, z blend pipeline
module tvs_back #(
  parameter int unsigned MAX_DIM_X = tvs_pkg::DEF_MAX_DIM_X,
  parameter int unsigned MAX_DIM_Y = tvs_pkg::DEF_MAX_DIM_Y,
  parameter int unsigned MAX_DIM_Z = tvs_pkg::DEF_MAX_DIM_Z,
  parameter int unsigned FRAC_BITS = tvs_pkg::DEF_FRAC_BITS,
  parameter type entry_t = logic
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  entry_t                        pop_data_i,
  output logic                          done_o,
  output logic [tvs_pkg::SAMPLE_W-1:0]  sample_value_o
);
  import tvs_pkg::*;

  localparam int unsigned STORE_SIZE = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam int unsigned ADDR_W = $clog2(STORE_SIZE);
  localparam int unsigned CNT_W = $clog2(READS);
  localparam int unsigned XW = VOXEL_W + FRAC_BITS;
  localparam int unsigned YW = VOXEL_W + 2 * FRAC_BITS;
  localparam int unsigned ZW = VOXEL_W + 3 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  back_state_e state_q, state_d;

  logic [VOXEL_W-1:0] mem [STORE_SIZE];

  entry_t            cur_q;
  entry_t            src;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  k;
  logic              idle_pop, load_pop, sample_pop;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic                 rd_vld_q;
  logic [CNT_W-1:0]     rd_k_q;
  logic [FRAC_BITS-1:0] rd_fx_q, rd_fy_q, rd_fz_q;
  logic [VOXEL_W-1:0]   rdata_q;

  logic                 x_vld_q;
  logic [1:0]           x_j_q;
  logic [FRAC_BITS-1:0] x_fy_q, x_fz_q;
  logic [XW-1:0]        xpart_q, xres_q, px;
  logic [FRAC_BITS:0]   wx;

  logic                 y_vld_q;
  logic                 y_m_q;
  logic [FRAC_BITS-1:0] y_fz_q;
  logic [YW-1:0]        ypart_q, yres_q, py;
  logic [FRAC_BITS:0]   wy;

  logic                 out_vld_q;
  logic [SAMPLE_W-1:0]  out_q;
  logic [ZW-1:0]        zpart_q, pz, zsum;
  logic [FRAC_BITS:0]   wz;

  assign idle_pop   = (state_q == B_IDLE) && pop_valid_i;
  assign load_pop   = idle_pop && pop_data_i.is_load;
  assign sample_pop = idle_pop && !pop_data_i.is_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (sample_pop) begin
          state_d = B_READ;
        end
      end
      B_READ: begin
        if (cnt_q == CNT_W'(READS - 1)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (sample_pop) begin
        cnt_q <= CNT_W'(1);
      end else if (state_q == B_READ) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // first read goes out straight from the queue head
  always_comb begin
    pop_o   = idle_pop;
    rd_en   = sample_pop || (state_q == B_READ);
    src     = (state_q == B_IDLE) ? pop_data_i : cur_q;
    k       = (state_q == B_IDLE) ? '0 : cnt_q;
    rd_addr = src.base[k[2:1]] + ADDR_W'(k[0] ? src.x1 : src.x0);
  end

  always_ff @(posedge clk_i) begin
    if (sample_pop) begin
      cur_q <= pop_data_i;
    end
    if (load_pop) begin
      mem[pop_data_i.load_addr] <= pop_data_i.load_value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rd_k_q  <= k;
      rd_fx_q <= src.fx;
      rd_fy_q <= src.fy;
      rd_fz_q <= src.fz;
    end
  end

  always_comb begin
    wx   = rd_k_q[0] ? {1'b0, rd_fx_q} : ONE - {1'b0, rd_fx_q};
    px   = XW'(rdata_q) * XW'(wx);
    wy   = x_j_q[0] ? {1'b0, x_fy_q} : ONE - {1'b0, x_fy_q};
    py   = YW'(xres_q) * YW'(wy);
    wz   = y_m_q ? {1'b0, y_fz_q} : ONE - {1'b0, y_fz_q};
    pz   = ZW'(yres_q) * ZW'(wz);
    zsum = zpart_q + pz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      x_vld_q   <= 1'b0;
      y_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      x_vld_q   <= rd_vld_q && rd_k_q[0];
      y_vld_q   <= x_vld_q && x_j_q[0];
      out_vld_q <= y_vld_q && y_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (!rd_k_q[0]) begin
        xpart_q <= px;
      end else begin
        xres_q <= xpart_q + px;
        x_j_q  <= rd_k_q[2:1];
        x_fy_q <= rd_fy_q;
        x_fz_q <= rd_fz_q;
      end
    end
    if (x_vld_q) begin
      if (!x_j_q[0]) begin
        ypart_q <= py;
      end else begin
        yres_q <= ypart_q + py;
        y_m_q  <= x_j_q[1];
        y_fz_q <= x_fz_q;
      end
    end
    if (y_vld_q) begin
      if (!y_m_q) begin
        zpart_q <= pz;
      end else begin
        out_q <= zsum[ZW-1 -: SAMPLE_W];
      end
    end
  end

  assign done_o         = out_vld_q;
  assign sample_value_o = out_q;

endmodule
